// ===== src/selective_repeat_packet_receiver_macros.svh =====
// Assertion macros shared by the receiver's modules.
`ifndef SELECTIVE_REPEAT_PACKET_RECEIVER_MACROS_SVH
`define SELECTIVE_REPEAT_PACKET_RECEIVER_MACROS_SVH
`ifndef SYNTHESIS
`define SRPR_ASSERT_CLK(clk, rst, label, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SRPR_ASSERT(label, prop, msg) \
   `SRPR_ASSERT_CLK(clock, reset, label, prop, msg)
`else
`define SRPR_ASSERT_CLK(clk, rst, label, prop, msg)
`define SRPR_ASSERT(label, prop, msg)
`endif
`endif

// ===== src/srpr_pkg.sv =====
// Shared types, constants and helpers of the selective-repeat receiver.
package srpr_pkg;

   localparam int PKT_BYTES   = 128;
   localparam int WINDOW      = 10;
   localparam int SEQ_MODULUS = 30;

   localparam int MAXP   = PKT_BYTES - 4;
   localparam int NBUF   = WINDOW + 1;
   localparam int POS_W  = $clog2(PKT_BYTES);
   localparam int SI_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int PH_W   = $clog2(NBUF);
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int ADDR_W = $clog2(NBUF * MAXP);

   // Fixed field widths of the channels.
   localparam int SEQ_W  = 5;
   localparam int SLOT_W = 4;
   localparam int SIZE_W = 7;
   localparam int OFF_W  = 7;
   localparam int SUM_W  = 16;

   // Reciprocal for taking a sequence number modulo the window.
   localparam int RCP_SH = 10;
   localparam int RCP_M  = ((1 << RCP_SH) + WINDOW - 1) / WINDOW;

   localparam logic [SUM_W-1:0] SUM_GOOD = 16'hffff;

   typedef enum logic {
      CMD_BYTE = 1'b0,
      CMD_READ = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_DELIV = 2'd1,
      KIND_ACK   = 2'd2
   } kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic byte_acc;
      logic read_acc;
      logic read_emit;
      logic chk_exec;
      logic drain_step;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pos_last;
      logic out_free;
      logic need_out;
      logic more_chk;
      logic more_drain;
   } dp_sts_type;

   // Ack checksum: ones' complement of the sequence number shifted up a byte.
   function automatic logic [SUM_W-1:0] ack_sum(input logic [SEQ_W-1:0] s);
      return ~{3'b000, s, 8'h00};
   endfunction

   // Slot of a sequence number below 64, by reciprocal multiply and one correction.
   function automatic logic [SI_W-1:0] slot_of(input logic [5:0] s);
      logic [15:0] prod;
      logic [15:0] q;
      logic [15:0] r;
      prod = 16'(s) * 16'(RCP_M);
      q    = prod >> RCP_SH;
      r    = 16'(s) - q * 16'(WINDOW);
      if (r >= 16'(WINDOW)) begin
         r = r - 16'(WINDOW);
      end
      return r[SI_W-1:0];
   endfunction

endpackage

// ===== src/srpr_ram.sv =====
// Generic RAM with one write port and one registered read port.
module srpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/srpr_ctrl.sv =====
// Controller state machine of the selective-repeat receiver.
`include "selective_repeat_packet_receiver_macros.svh"
module srpr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_tuser,
   input  srpr_pkg::dp_sts_type sts,
   output srpr_pkg::ctl_cmd_type cmd
);
   import srpr_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_READ  = 4'b0010,
      S_CHECK = 4'b0100,
      S_DRAIN = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (cmd_type'(req_tuser) == CMD_READ) begin
                  cmd.read_acc = 1'b1;
                  state_in     = S_READ;
               end else begin
                  cmd.byte_acc = 1'b1;
                  if (sts.pos_last) begin
                     state_in = S_CHECK;
                  end
               end
            end
         end
         S_READ: begin
            if (sts.out_free) begin
               cmd.read_emit = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_CHECK: begin
            if (!sts.need_out || sts.out_free) begin
               cmd.chk_exec = 1'b1;
               state_in     = (sts.need_out && sts.more_chk) ? S_DRAIN : S_IDLE;
            end
         end
         S_DRAIN: begin
            if (sts.out_free) begin
               cmd.drain_step = 1'b1;
               if (!sts.more_drain) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `SRPR_ASSERT(a_read_follows_idle, (state_ff == S_READ) |-> $past(state_ff == S_IDLE || state_ff == S_READ), "read state entered from elsewhere than idle")
   `SRPR_ASSERT(a_drain_after_check, $rose(state_ff == S_DRAIN) |-> $past(state_ff == S_CHECK), "drain entered without a check")

endmodule

// ===== src/srpr_dp.sv =====
// Datapath of the selective-repeat receiver: checksum, window, slots and result register.
`include "selective_repeat_packet_receiver_macros.svh"
module srpr_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  srpr_pkg::ctl_cmd_type         cmd,
   output srpr_pkg::dp_sts_type          sts,
   input  logic [7:0]                    data_byte,
   input  logic [srpr_pkg::SLOT_W-1:0]   read_slot,
   input  logic [srpr_pkg::OFF_W-1:0]    read_offset,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output srpr_pkg::kind_type            out_kind,
   output logic [srpr_pkg::SEQ_W-1:0]    out_seq,
   output logic [srpr_pkg::SLOT_W-1:0]   out_slot,
   output logic [srpr_pkg::SIZE_W-1:0]   out_size,
   output logic [srpr_pkg::SUM_W-1:0]    out_ack,
   output logic [7:0]                    out_rbyte,
   output logic                          out_last
);
   import srpr_pkg::*;

   // Receive state.
   logic [POS_W-1:0]  pos_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic              pkt_ok_ff;
   logic [7:0]        hdr_size_ff;
   logic [7:0]        hdr_seq_ff;
   logic [SEQ_W-1:0]  exp_ff;
   logic [SI_W-1:0]   eslot_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              buf_ff [WINDOW];
   logic [SIZE_W-1:0] size_ff [WINDOW];
   logic [PH_W-1:0]   map_ff [WINDOW];
   logic [PH_W-1:0]   free_ff;
   logic              rd_oor_ff;

   // Result register.
   logic              valid_ff;
   kind_type          kind_ff;
   logic [SEQ_W-1:0]  seq_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [SIZE_W-1:0] osize_ff;
   logic [SUM_W-1:0]  ack_ff;
   logic [7:0]        rbyte_ff;
   logic              last_ff;

   logic [SUM_W-1:0]   word;
   logic [SUM_W:0]     sum_add;
   logic [SUM_W-1:0]   sum_fold;
   logic               pos_last;
   logic               pay_wr;
   logic [ADDR_W-1:0]  wr_addr;
   logic               rd_in_range;
   logic [SI_W-1:0]    rd_idx;
   logic [SI_W-1:0]    map_idx;
   logic [PH_W-1:0]    map_q;
   logic [ADDR_W-1:0]  rd_addr;
   logic [7:0]         ram_q;
   logic               seq_valid;
   logic [SI_W-1:0]    cslot;
   logic [6:0]         gap_raw;
   logic [6:0]         seq_gap;
   logic               drop;
   logic               deliver;
   logic               in_win;
   logic               buffer_it;
   logic               ack_only;
   logic [SIZE_W-1:0]  clamp_size;
   logic [SEQ_W-1:0]   nexp;
   logic [SI_W-1:0]    nslot;
   logic               nb_next;
   logic               out_free;
   logic               more_chk;
   logic               more_drain;

   // Checksum accumulation in ones' complement.
   assign word     = pos_ff[0] ? {8'h00, data_byte} : {data_byte, 8'h00};
   assign sum_add  = {1'b0, sum_ff} + {1'b0, word};
   assign sum_fold = sum_add[SUM_W] ? (sum_add[SUM_W-1:0] + 16'd1) : sum_add[SUM_W-1:0];
   assign pos_last = (pos_ff == POS_W'(PKT_BYTES - 1));

   // Payload bytes go straight into the free buffer.
   assign pay_wr  = cmd.byte_acc && (pos_ff >= POS_W'(2)) && (pos_ff < POS_W'(PKT_BYTES - 2));
   assign wr_addr = ADDR_W'(free_ff) * ADDR_W'(MAXP) + ADDR_W'(pos_ff - POS_W'(2));

   // Read address through the slot map.
   assign rd_in_range = (read_slot < SLOT_W'(WINDOW)) && (read_offset < OFF_W'(MAXP));
   assign rd_idx      = rd_in_range ? read_slot[SI_W-1:0] : '0;
   assign map_idx     = cmd.read_acc ? rd_idx : cslot;
   assign map_q       = map_ff[map_idx];
   assign rd_addr     = ADDR_W'(map_q) * ADDR_W'(MAXP)
                      + ADDR_W'(rd_in_range ? read_offset : '0);

   srpr_ram #(
      .WIDTH (8),
      .DEPTH (NBUF * MAXP)
   ) u_ram (
      .clock   (clock),
      .wr_en   (pay_wr),
      .wr_addr (wr_addr),
      .wr_data (data_byte),
      .rd_en   (cmd.read_acc),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // End-of-packet classification.
   assign seq_valid  = (hdr_seq_ff < 8'(SEQ_MODULUS));
   assign cslot      = slot_of(hdr_seq_ff[5:0]);
   assign gap_raw    = 7'(hdr_seq_ff[5:0]) + 7'(SEQ_MODULUS) - 7'(exp_ff);
   assign seq_gap    = (gap_raw >= 7'(SEQ_MODULUS)) ? (gap_raw - 7'(SEQ_MODULUS)) : gap_raw;
   assign drop       = !pkt_ok_ff || !seq_valid;
   assign deliver    = !drop && (hdr_seq_ff == 8'(exp_ff));
   assign in_win     = (seq_gap >= 7'd1) && (seq_gap < 7'(WINDOW)) && !buf_ff[cslot];
   assign buffer_it  = !drop && !deliver && in_win;
   assign ack_only   = !drop && !deliver && !in_win;
   assign clamp_size = (hdr_size_ff > 8'(MAXP)) ? SIZE_W'(MAXP) : hdr_size_ff[SIZE_W-1:0];

   // Next expected number and whether its slot waits for delivery.
   assign nexp    = (exp_ff == SEQ_W'(SEQ_MODULUS - 1)) ? '0 : exp_ff + SEQ_W'(1);
   assign nslot   = ((exp_ff == SEQ_W'(SEQ_MODULUS - 1)) || (eslot_ff == SI_W'(WINDOW - 1)))
                  ? '0 : eslot_ff + SI_W'(1);
   assign nb_next = buf_ff[nslot] && (nslot != eslot_ff);

   assign out_free   = !valid_ff || rsp_tready;
   assign more_chk   = deliver && (WINDOW > 1) && nb_next;
   assign more_drain = ((CNT_W + 1)'(cnt_ff) + (CNT_W + 1)'(1) < (CNT_W + 1)'(WINDOW)) && nb_next;

   assign sts.pos_last   = pos_last;
   assign sts.out_free   = out_free;
   assign sts.need_out   = deliver || ack_only;
   assign sts.more_chk   = more_chk;
   assign sts.more_drain = more_drain;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         sum_ff    <= '0;
         pkt_ok_ff <= 1'b0;
         exp_ff    <= '0;
         eslot_ff  <= '0;
         cnt_ff    <= '0;
         free_ff   <= PH_W'(WINDOW);
         valid_ff  <= 1'b0;
         for (int i = 0; i < WINDOW; i++) begin
            buf_ff[i] <= 1'b0;
            map_ff[i] <= PH_W'(i);
         end
      end else begin
         if (valid_ff && rsp_tready) begin
            valid_ff <= 1'b0;
         end
         if (cmd.byte_acc) begin
            if (pos_last) begin
               pos_ff    <= '0;
               sum_ff    <= '0;
               pkt_ok_ff <= (sum_fold == SUM_GOOD);
            end else begin
               pos_ff <= pos_ff + POS_W'(1);
               sum_ff <= sum_fold;
            end
         end
         if (cmd.read_emit) begin
            valid_ff <= 1'b1;
         end
         if (cmd.chk_exec) begin
            if (deliver || buffer_it) begin
               map_ff[cslot] <= free_ff;
               free_ff       <= map_q;
               buf_ff[cslot] <= buffer_it;
            end
            if (deliver) begin
               exp_ff   <= nexp;
               eslot_ff <= nslot;
               cnt_ff   <= CNT_W'(1);
            end
            if (deliver || ack_only) begin
               valid_ff <= 1'b1;
            end
         end
         if (cmd.drain_step) begin
            buf_ff[eslot_ff] <= 1'b0;
            exp_ff           <= nexp;
            eslot_ff         <= nslot;
            cnt_ff           <= cnt_ff + CNT_W'(1);
            valid_ff         <= 1'b1;
         end
      end
   end

   // Header, slot size and result payload registers.
   always_ff @(posedge clock) begin
      if (cmd.byte_acc && (pos_ff == POS_W'(0))) begin
         hdr_size_ff <= data_byte;
      end
      if (cmd.byte_acc && (pos_ff == POS_W'(1))) begin
         hdr_seq_ff <= data_byte;
      end
      if (cmd.read_acc) begin
         rd_oor_ff <= !rd_in_range;
      end
      if (cmd.chk_exec && (deliver || buffer_it)) begin
         size_ff[cslot] <= clamp_size;
      end
      if (cmd.read_emit) begin
         kind_ff  <= KIND_READ;
         seq_ff   <= '0;
         slot_ff  <= '0;
         osize_ff <= '0;
         ack_ff   <= '0;
         rbyte_ff <= rd_oor_ff ? 8'h00 : ram_q;
         last_ff  <= 1'b1;
      end
      if (cmd.chk_exec && deliver) begin
         kind_ff  <= KIND_DELIV;
         seq_ff   <= hdr_seq_ff[SEQ_W-1:0];
         slot_ff  <= SLOT_W'(cslot);
         osize_ff <= clamp_size;
         ack_ff   <= ack_sum(hdr_seq_ff[SEQ_W-1:0]);
         rbyte_ff <= 8'h00;
         last_ff  <= !more_chk;
      end
      if (cmd.chk_exec && ack_only) begin
         kind_ff  <= KIND_ACK;
         seq_ff   <= hdr_seq_ff[SEQ_W-1:0];
         slot_ff  <= '0;
         osize_ff <= '0;
         ack_ff   <= ack_sum(hdr_seq_ff[SEQ_W-1:0]);
         rbyte_ff <= 8'h00;
         last_ff  <= 1'b1;
      end
      if (cmd.drain_step) begin
         kind_ff  <= KIND_DELIV;
         seq_ff   <= exp_ff;
         slot_ff  <= SLOT_W'(eslot_ff);
         osize_ff <= size_ff[eslot_ff];
         ack_ff   <= ack_sum(exp_ff);
         rbyte_ff <= 8'h00;
         last_ff  <= !more_drain;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign out_kind   = kind_ff;
   assign out_seq    = seq_ff;
   assign out_slot   = slot_ff;
   assign out_size   = osize_ff;
   assign out_ack    = ack_ff;
   assign out_rbyte  = rbyte_ff;
   assign out_last   = last_ff;

   `SRPR_ASSERT(a_drain_bounded, cnt_ff <= CNT_W'(WINDOW), "drain count beyond window")
   `SRPR_ASSERT(a_read_single, (valid_ff && kind_ff == KIND_READ) |-> last_ff, "read word not marked last")
   `SRPR_ASSERT_CLK(clock, reset, a_free_unmapped, (cmd.chk_exec && (deliver || buffer_it)) |=> (map_ff[$past(cslot)] == $past(free_ff)), "slot map not swapped on store")

endmodule

// ===== src/selective_repeat_packet_receiver.sv =====
// Top level of the selective-repeat packet receiver.
//
// The req channel carries one word per packet byte (tuser low) or a payload read
// (tuser high). Packets are PKT_BYTES words long: size, sequence, payload and a
// 16-bit checksum. Good in-order packets give a delivery word on rsp, followed
// by one word for each buffered successor; duplicates and packets outside the
// window give a single ack word; bad packets give nothing.
// Throughput: one packet byte per cycle while the controller is idle. The last
// byte of a packet is followed by a classification step, and each drained
// successor by a drain step; both wait for the single result register. A read
// is accepted together with the registered payload RAM read, and the result
// register is loaded from it in a later step, once it can take a word.
// The payload RAM has WINDOW+1 buffers; a slot map swaps the filled buffer in
// when a packet is stored, so no copy is made.
// Reset clears the window, the expected number, the byte position and the slot
// map; payload contents are not cleared and no clearing pass is run.
// When rsp_tready is low the result register holds its word. Bytes within a
// packet are still taken, but a read or a packet end that has a word to send
// waits, and the input with it, until the result register can be loaded again.
module selective_repeat_packet_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // command
   input  logic [23:0] req_tdata,   // data_byte, read_slot, read_offset, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // kind
   output logic [39:0] rsp_tdata,   // seq, slot, payload_size, ack_checksum, read_byte
   output logic        rsp_tlast
);
   import srpr_pkg::*;

   ctl_cmd_type       cmd;
   dp_sts_type        sts;
   kind_type          out_kind;
   logic [SEQ_W-1:0]  out_seq;
   logic [SLOT_W-1:0] out_slot;
   logic [SIZE_W-1:0] out_size;
   logic [SUM_W-1:0]  out_ack;
   logic [7:0]        out_rbyte;

   // Sequencing of bytes, reads and drains.
   srpr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Checksum, window bookkeeping, payload store and result register.
   srpr_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .data_byte   (req_tdata[7:0]),
      .read_slot   (req_tdata[11:8]),
      .read_offset (req_tdata[18:12]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .out_kind    (out_kind),
      .out_seq     (out_seq),
      .out_slot    (out_slot),
      .out_size    (out_size),
      .out_ack     (out_ack),
      .out_rbyte   (out_rbyte),
      .out_last    (rsp_tlast)
   );

   assign rsp_tuser = out_kind;
   assign rsp_tdata = {out_rbyte, out_ack, out_size, out_slot, out_seq};

endmodule
